// File: sv/eth_ipv4_tcp_header_extractor_assert.svh
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_extractor_assert.svh
// Assertion macros for the header extractor; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_TCP_HEADER_EXTRACTOR_ASSERT_SVH
`define ETH_IPV4_TCP_HEADER_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ETHX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ethx: same-cycle check failed");
// next-cycle implication
`define ETHX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ethx: next-cycle check failed");
`else
`define ETHX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ETHX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/ethx_pkg.sv
// ----------------------------------------------------------------------------
// ethx_pkg
// Shared types and constants of the Ethernet/IPv4/TCP header extractor.
// ----------------------------------------------------------------------------
package ethx_pkg;

	// protocol constants
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
	localparam logic [7:0]  DOT_CHAR       = 8'h2E;
	localparam logic [7:0]  PRINT_LO       = 8'h20;
	localparam logic [7:0]  PRINT_HI       = 8'h7E;
	localparam logic [7:0]  LIMIT_RESET    = 8'd32;
	localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

	// record kinds
	localparam logic [1:0] KIND_HEADER     = 2'd0;
	localparam logic [1:0] KIND_CHAR       = 2'd1;
	localparam logic [1:0] KIND_NO_PAYLOAD = 2'd2;

	// result queue depth (at least 4: one beat out, two in per cycle)
	localparam int RQ_DEPTH_DEFAULT = 4;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} ethx_in_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  payload_char;
		logic        report_last;
	} ethx_rec_t;

	// pushes from parser into result queue
	typedef struct packed {
		logic first;
		logic second;
	} ethx_push_t;

endpackage

// File: sv/eth_ipv4_tcp_header_extractor.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_extractor
// Ethernet/IPv4/TCP header extractor with payload character report.
// ----------------------------------------------------------------------------
// Usage:
//   Frame bytes enter on byte_valid/byte_stall with byte_data (frame_byte and
//   frame_end on the last byte). Records leave on rec_valid/rec_stall with
//   rec_data: one header record at the last TCP header byte, then payload
//   characters, or a no-payload marker right behind the header record.
//   Non-IPv4, non-TCP, short and malformed frames produce nothing.
//   limit_we/limit_wdata set the payload character limit (reset 32); write
//   it only while no frame is being reported.
// Timing:
//   A byte is registered on accept and parsed from that register once the
//   queue has room; the parse writes its records into the result queue
//   (RQ_DEPTH entries, four by default), whose head drives the output.
//   One byte per cycle is sustained while the output drains. A header
//   record with its no-payload marker puts two records in at once and still
//   fits; the parse stage waits only while the queue holds more than
//   RQ_DEPTH - 2 records.
// Reset:
//   arst_n clears all frame state, the queue, and the limit to 32.
// Stall:
//   With rec_stall high the queue fills; byte_stall rises once it holds
//   more than RQ_DEPTH - 2 records and a byte is waiting in the parse stage.
// ----------------------------------------------------------------------------
`include "eth_ipv4_tcp_header_extractor_assert.svh"

module eth_ipv4_tcp_header_extractor #(
	parameter int RQ_DEPTH = ethx_pkg::RQ_DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  ethx_pkg::ethx_in_t  byte_data,
	output logic                rec_valid,
	input  logic                rec_stall,
	output ethx_pkg::ethx_rec_t rec_data,
	input  logic                limit_we,
	input  logic [7:0]          limit_wdata
);
	import ethx_pkg::*;

	localparam int CW = $clog2(RQ_DEPTH + 1);
	localparam logic [CW-1:0] ROOM_LEVEL = CW'(RQ_DEPTH - 2);

	ethx_in_t      byte_s1;
	logic          valid_s1;
	logic          advance;
	logic [7:0]    limit_q;
	ethx_push_t    push;
	ethx_rec_t     rec0, rec1;
	logic [CW-1:0] rq_count;
	logic          pop;

	// parse stage moves when the queue has room for two records
	assign advance    = valid_s1 && (rq_count <= ROOM_LEVEL);
	assign byte_stall = valid_s1 && !advance;
	assign pop        = rec_valid && !rec_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) byte_s1 <= byte_data;
	end

	// payload limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	ethx_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (byte_s1),
		.limit  (limit_q),
		.push   (push),
		.rec0   (rec0),
		.rec1   (rec1)
	);

	ethx_rq #(
		.DEPTH (RQ_DEPTH)
	) u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rec0       (rec0),
		.rec1       (rec1),
		.pop        (pop),
		.head_valid (rec_valid),
		.head       (rec_data),
		.count      (rq_count)
	);

	// checks
	`ETHX_ASSERT_IMPLY(a_no_push_when_full, clk, arst_n, rq_count > ROOM_LEVEL, !push.first)
	`ETHX_ASSERT_IMPLY(a_second_needs_first, clk, arst_n, push.second, push.first)
	`ETHX_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, rq_count <= CW'(RQ_DEPTH))
	`ETHX_ASSERT_NEXT(a_stall_holds_byte, clk, arst_n, byte_stall, valid_s1)

endmodule

// File: sv/ethx_parser.sv
// ----------------------------------------------------------------------------
// ethx_parser
// Per-byte frame parser: captures header fields and builds up to two
// result records for the byte presented on a cycle with go high.
// ----------------------------------------------------------------------------
module ethx_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  ethx_pkg::ethx_in_t  item,
	input  logic [7:0]          limit,
	output ethx_pkg::ethx_push_t push,
	output ethx_pkg::ethx_rec_t rec0,
	output ethx_pkg::ethx_rec_t rec1
);
	import ethx_pkg::*;

	logic [15:0] pos_q, pos_d;
	logic [47:0] dmac_q, dmac_d;
	logic [47:0] smac_q, smac_d;
	logic [7:0]  type_hi_q, type_hi_d;
	logic [3:0]  ihl_q, ihl_d;
	logic [15:0] total_q, total_d;
	logic [31:0] saddr_q, saddr_d;
	logic [31:0] daddr_q, daddr_d;
	logic [31:0] ports_q, ports_d;
	logic [3:0]  thw_q, thw_d;
	logic        dropped_q, dropped_d;
	logic        hdr_rep_q, hdr_rep_d;
	logic [7:0]  chars_q, chars_d;
	logic [7:0]  pcount_q, pcount_d;

	logic [7:0]  b;
	logic [6:0]  tcp_start;
	logic [15:0] rel;
	logic [6:0]  hdr_bytes;
	logic [15:0] plen;
	logic [7:0]  cnt;
	logic [7:0]  pchar;
	logic        last;

	assign b = item.frame_byte;

	// TCP header offset, relative position and payload length
	assign tcp_start = ETH_HDR_LEN + {1'b0, ihl_q, 2'b00};
	assign rel       = pos_q - {9'd0, tcp_start};
	assign hdr_bytes = {1'b0, ihl_q, 2'b00} + {1'b0, thw_q, 2'b00};
	assign plen      = (total_q > {9'd0, hdr_bytes}) ? total_q - {9'd0, hdr_bytes} : 16'd0;
	assign cnt       = (plen > {8'd0, limit}) ? limit : plen[7:0];
	assign pchar     = (b >= PRINT_LO && b <= PRINT_HI) ? b : DOT_CHAR;

	// next state and results
	always_comb begin
		pos_d     = pos_q;
		dmac_d    = dmac_q;
		smac_d    = smac_q;
		type_hi_d = type_hi_q;
		ihl_d     = ihl_q;
		total_d   = total_q;
		saddr_d   = saddr_q;
		daddr_d   = daddr_q;
		ports_d   = ports_q;
		thw_d     = thw_q;
		dropped_d = dropped_q;
		hdr_rep_d = hdr_rep_q;
		chars_d   = chars_q;
		pcount_d  = pcount_q;
		push      = '0;
		rec0      = '0;
		rec1      = '0;
		last      = 1'b0;
		if (go) begin
			if (!dropped_q) begin
				if (hdr_rep_q) begin
					// payload byte
					chars_d = chars_q + 8'd1;
					last    = item.frame_end || (chars_d >= pcount_q);
					push.first        = 1'b1;
					rec0.record_kind  = KIND_CHAR;
					rec0.payload_char = pchar;
					rec0.report_last  = last;
					if (last) dropped_d = 1'b1;
				end else if (pos_q < 16'd6) begin
					dmac_d = {dmac_q[39:0], b};
				end else if (pos_q < 16'd12) begin
					smac_d = {smac_q[39:0], b};
				end else if (pos_q == 16'd12) begin
					type_hi_d = b;
				end else if (pos_q == 16'd13) begin
					if ({type_hi_q, b} != ETHERTYPE_IPV4) dropped_d = 1'b1;
				end else if (pos_q == 16'd14) begin
					ihl_d = b[3:0];
					if (b[3:0] < MIN_HDR_WORDS) dropped_d = 1'b1;
				end else if (pos_q == 16'd16 || pos_q == 16'd17) begin
					total_d = {total_q[7:0], b};
				end else if (pos_q == 16'd23) begin
					if (b != PROTO_TCP) dropped_d = 1'b1;
				end else if (pos_q >= 16'd26 && pos_q < 16'd30) begin
					saddr_d = {saddr_q[23:0], b};
				end else if (pos_q >= 16'd30 && pos_q < 16'd34) begin
					daddr_d = {daddr_q[23:0], b};
				end else if (pos_q >= {9'd0, tcp_start}) begin
					// TCP header
					if (rel < 16'd4) ports_d = {ports_q[23:0], b};
					if (rel == 16'd12) begin
						thw_d = b[7:4];
						if (b[7:4] < MIN_HDR_WORDS) dropped_d = 1'b1;
					end
					if (!dropped_d && rel >= 16'd12 &&
					    rel == {10'd0, thw_d, 2'b00} - 16'd1) begin
						push.first       = 1'b1;
						rec0.record_kind = KIND_HEADER;
						rec0.dest_mac    = dmac_q;
						rec0.source_mac  = smac_q;
						rec0.source_addr = saddr_q;
						rec0.dest_addr   = daddr_q;
						rec0.source_port = ports_q[31:16];
						rec0.dest_port   = ports_q[15:0];
						if (item.frame_end || cnt == 8'd0) begin
							push.second      = 1'b1;
							rec1.record_kind = KIND_NO_PAYLOAD;
							rec1.report_last = 1'b1;
							dropped_d        = 1'b1;
						end else begin
							hdr_rep_d = 1'b1;
							pcount_d  = cnt;
							chars_d   = 8'd0;
						end
					end
				end
				if (pos_q != 16'hFFFF) pos_d = pos_q + 16'd1;
			end
			// frame end resets the per-frame state
			if (item.frame_end) begin
				pos_d     = 16'd0;
				dropped_d = 1'b0;
				hdr_rep_d = 1'b0;
				chars_d   = 8'd0;
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			dmac_q    <= '0;
			smac_q    <= '0;
			type_hi_q <= '0;
			ihl_q     <= '0;
			total_q   <= '0;
			saddr_q   <= '0;
			daddr_q   <= '0;
			ports_q   <= '0;
			thw_q     <= '0;
			dropped_q <= 1'b0;
			hdr_rep_q <= 1'b0;
			chars_q   <= '0;
			pcount_q  <= '0;
		end else begin
			pos_q     <= pos_d;
			dmac_q    <= dmac_d;
			smac_q    <= smac_d;
			type_hi_q <= type_hi_d;
			ihl_q     <= ihl_d;
			total_q   <= total_d;
			saddr_q   <= saddr_d;
			daddr_q   <= daddr_d;
			ports_q   <= ports_d;
			thw_q     <= thw_d;
			dropped_q <= dropped_d;
			hdr_rep_q <= hdr_rep_d;
			chars_q   <= chars_d;
			pcount_q  <= pcount_d;
		end
	end

endmodule

// File: sv/ethx_rq.sv
// ----------------------------------------------------------------------------
// ethx_rq
// Result queue: takes up to two records per cycle, hands out one beat.
// ----------------------------------------------------------------------------
module ethx_rq #(
	parameter int DEPTH = ethx_pkg::RQ_DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ethx_pkg::ethx_push_t       push,
	input  ethx_pkg::ethx_rec_t        rec0,
	input  ethx_pkg::ethx_rec_t        rec1,
	input  logic                       pop,
	output logic                       head_valid,
	output ethx_pkg::ethx_rec_t        head,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import ethx_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

	ethx_rec_t     mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW-1:0] wr_nxt, wr_nxt2;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_push;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		inc = (p == LAST_IDX) ? '0 : p + PW'(1);
	endfunction

	assign wr_nxt     = inc(wr_q);
	assign wr_nxt2    = inc(wr_nxt);
	assign n_push     = CW'(push.first) + CW'(push.second);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign count      = cnt_q;

	// payload storage
	always_ff @(posedge clk) begin
		if (push.first) mem_q[wr_q] <= rec0;
		if (push.second) mem_q[wr_nxt] <= rec1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.second) wr_q <= wr_nxt2;
			else if (push.first) wr_q <= wr_nxt;
			if (pop) rd_q <= inc(rd_q);
			cnt_q <= cnt_q + n_push - CW'(pop);
		end
	end

endmodule

// File: test/eth_ipv4_tcp_header_extractor_tb.sv
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_extractor_tb
// Self-checking bench for the Ethernet/IPv4/TCP header extractor. Frames are
// built byte by byte (good TCP frames, foreign EtherTypes and protocols, bad
// IHL and data offset, short and noise frames), driven with random gaps, and
// every record the block emits is compared field by field against an
// in-bench model of the parser. The payload limit is changed between phases.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ethx_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int ITEM_GOAL     = 1050;

	// ------------------------------------------------------------------------
	// Parser model and store of the records it predicts
	// ------------------------------------------------------------------------
	class HeaderReportScoreboard;
		logic [7:0]  limit;
		logic [15:0] position;
		logic [47:0] dmac;
		logic [47:0] smac;
		logic [7:0]  type_hi;
		logic [3:0]  ihl_words;
		logic [3:0]  tcp_words;
		logic [15:0] ip_length;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [31:0] ports;
		bit          dropped;
		bit          header_done;
		logic [7:0]  chars_sent;
		logic [7:0]  chars_due;
		ethx_rec_t   expected_recs[$];
		int          errors;
		int          in_beats;

		function new();
			limit       = LIMIT_RESET;
			position    = '0;
			dmac        = '0;
			smac        = '0;
			type_hi     = '0;
			ihl_words   = '0;
			tcp_words   = '0;
			ip_length   = '0;
			saddr       = '0;
			daddr       = '0;
			ports       = '0;
			dropped     = 1'b0;
			header_done = 1'b0;
			chars_sent  = '0;
			chars_due   = '0;
			errors      = 0;
			in_beats    = 0;
		endfunction

		function logic [7:0] shown_char(logic [7:0] b);
			return (b >= PRINT_LO && b <= PRINT_HI) ? b : DOT_CHAR;
		endfunction

		function void push_record(logic [1:0] kind, bit with_header, logic [7:0] ch,
				bit is_last);
			ethx_rec_t rec;
			rec = '0;
			rec.record_kind = kind;
			if (with_header) begin
				rec.dest_mac    = dmac;
				rec.source_mac  = smac;
				rec.source_addr = saddr;
				rec.dest_addr   = daddr;
				rec.source_port = ports[31:16];
				rec.dest_port   = ports[15:0];
			end
			rec.payload_char = ch;
			rec.report_last  = is_last;
			expected_recs.push_back(rec);
		endfunction

		// one accepted input beat
		function void note_byte(ethx_in_t beat);
			logic [7:0]  b;
			bit          fin;
			bit          is_last;
			int unsigned p;
			int unsigned t;
			int unsigned r;
			int unsigned cnt;
			int          plen;
			b   = beat.frame_byte;
			fin = beat.frame_end;
			in_beats++;
			if (!dropped) begin
				p = position;
				if (header_done) begin
					// payload character
					chars_sent = chars_sent + 8'd1;
					is_last = fin || (chars_sent >= chars_due);
					push_record(KIND_CHAR, 1'b0, shown_char(b), is_last);
					if (is_last)
						dropped = 1'b1;
				end else if (p < 6) begin
					dmac = {dmac[39:0], b};
				end else if (p < 12) begin
					smac = {smac[39:0], b};
				end else if (p == 12) begin
					type_hi = b;
				end else if (p == 13) begin
					if ({type_hi, b} != ETHERTYPE_IPV4)
						dropped = 1'b1;
				end else if (p == 14) begin
					ihl_words = b[3:0];
					if (ihl_words < MIN_HDR_WORDS)
						dropped = 1'b1;
				end else if (p == 16 || p == 17) begin
					ip_length = {ip_length[7:0], b};
				end else if (p == 23) begin
					if (b != PROTO_TCP)
						dropped = 1'b1;
				end else if (p >= 26 && p < 30) begin
					saddr = {saddr[23:0], b};
				end else if (p >= 30 && p < 34) begin
					daddr = {daddr[23:0], b};
				end else begin
					// TCP header
					t = 32'(ETH_HDR_LEN) + 32'(ihl_words) * 4;
					if (p >= t) begin
						r = p - t;
						if (r < 4)
							ports = {ports[23:0], b};
						if (r == 12) begin
							tcp_words = b[7:4];
							if (tcp_words < MIN_HDR_WORDS)
								dropped = 1'b1;
						end
						if (!dropped && r >= 12 && r == 32'(tcp_words) * 4 - 1) begin
							plen = int'(ip_length) - int'(ihl_words) * 4
								- int'(tcp_words) * 4;
							cnt = 0;
							if (plen > 0) begin
								cnt = plen;
								if (cnt > limit)
									cnt = limit;
							end
							push_record(KIND_HEADER, 1'b1, 8'h00, 1'b0);
							if (fin || cnt == 0) begin
								push_record(KIND_NO_PAYLOAD, 1'b0, 8'h00, 1'b1);
								dropped = 1'b1;
							end else begin
								header_done = 1'b1;
								chars_due   = cnt[7:0];
								chars_sent  = '0;
							end
						end
					end
				end
				if (position != 16'hFFFF)
					position = position + 16'd1;
			end
			if (fin) begin
				position    = '0;
				dropped     = 1'b0;
				header_done = 1'b0;
				chars_sent  = '0;
			end
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h",
					$time, name, want, got);
			end
		endfunction

		// one accepted output beat
		function void check_record(ethx_rec_t got);
			ethx_rec_t want;
			if (expected_recs.size() == 0) begin
				errors++;
				$display("%0t: unexpected record, expected none, actual %h",
					$time, got);
				return;
			end
			want = expected_recs.pop_front();
			check_field("record_kind", want.record_kind, got.record_kind);
			check_field("dest_mac", want.dest_mac, got.dest_mac);
			check_field("source_mac", want.source_mac, got.source_mac);
			check_field("source_addr", want.source_addr, got.source_addr);
			check_field("dest_addr", want.dest_addr, got.dest_addr);
			check_field("source_port", want.source_port, got.source_port);
			check_field("dest_port", want.dest_port, got.dest_port);
			check_field("payload_char", want.payload_char, got.payload_char);
			check_field("report_last", want.report_last, got.report_last);
		endfunction

		function void close_out();
			if (expected_recs.size() != 0) begin
				errors++;
				$display("%0t: %0d records missing, expected %h, actual none",
					$time, expected_recs.size(), expected_recs[0]);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and DUT
	// ------------------------------------------------------------------------
	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	ethx_in_t   byte_data;
	logic       rec_valid;
	logic       rec_stall;
	ethx_rec_t  rec_data;
	logic       limit_we;
	logic [7:0] limit_wdata;

	HeaderReportScoreboard sb;
	bit         steady_send;
	bit         hold_request;
	logic [7:0] frame_buf[$];

	eth_ipv4_tcp_header_extractor DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.rec_data    (rec_data),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Frame construction
	// ------------------------------------------------------------------------
	function automatic void put_byte(int unsigned at, logic [7:0] v);
		if (at < frame_buf.size())
			frame_buf[at] = v;
	endfunction

	// random frame of cap bytes with the parsed header fields set
	function automatic void build_frame(logic [15:0] etype, logic [3:0] ihl,
			logic [7:0] proto, logic [3:0] tcpw, int unsigned tot, int unsigned cap);
		int unsigned tcp_at;
		int unsigned hend;
		logic [3:0]  version;
		frame_buf.delete();
		tcp_at = 14 + ((ihl < MIN_HDR_WORDS) ? 5 : ihl) * 4;
		hend   = tcp_at + ((tcpw < MIN_HDR_WORDS) ? 5 : tcpw) * 4;
		for (int unsigned i = 0; i < cap; i++) begin
			if (i >= hend && $urandom_range(0, 1) == 1)
				frame_buf.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
			else
				frame_buf.push_back(8'($urandom_range(0, 255)));
		end
		version = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h4;
		put_byte(12, etype[15:8]);
		put_byte(13, etype[7:0]);
		put_byte(14, {version, ihl});
		put_byte(16, tot[15:8]);
		put_byte(17, tot[7:0]);
		put_byte(23, proto);
		put_byte(tcp_at + 12, {tcpw, 4'($urandom)});
	endfunction

	// ------------------------------------------------------------------------
	// Input driver
	// ------------------------------------------------------------------------
	task automatic push_byte(input ethx_in_t beat);
		int unsigned gap;
		gap = steady_send ? 0 : pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= beat;
		do
			@(posedge clk);
		while (byte_stall !== 1'b0);
		sb.note_byte(beat);
		@(negedge clk);
	endtask

	task automatic send_frame();
		ethx_in_t beat;
		for (int i = 0; i < frame_buf.size(); i++) begin
			beat.frame_byte = frame_buf[i];
			beat.frame_end  = (i == frame_buf.size() - 1);
			push_byte(beat);
		end
	endtask

	// idle the input until every predicted record has come out
	task automatic wait_drained();
		byte_valid <= 1'b0;
		do begin
			while (sb.expected_recs.size() != 0)
				@(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
		end while (sb.expected_recs.size() != 0);
	endtask

	task automatic write_limit(input logic [7:0] v);
		limit_we    <= 1'b1;
		limit_wdata <= v;
		sb.limit = v;
		@(negedge clk);
		limit_we    <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Directed frames
	// ------------------------------------------------------------------------
	task automatic run_directed();
		logic [7:0] edge_bytes[6];
		edge_bytes = '{8'h00, 8'hFF, 8'h20, 8'h7E, 8'h1F, 8'h7F};
		// minimal TCP frame, payload on the printable boundaries
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 46, 60);
		for (int i = 0; i < 6; i++)
			put_byte(54 + i, edge_bytes[i]);
		send_frame();
		// not IPv4, not TCP
		build_frame(16'h86DD, 4'd5, PROTO_TCP, 4'd5, 40, 16);
		send_frame();
		build_frame(ETHERTYPE_IPV4, 4'd5, 8'd17, 4'd5, 40, 26);
		send_frame();
		// bad IHL and bad data offset
		build_frame(ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 4'd5, 40, 16);
		send_frame();
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd4, 40, 50);
		send_frame();
		// frame ends one byte before the end of the TCP header
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 50, 53);
		send_frame();
		// frame ends on the last header byte with payload due
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 50, 54);
		send_frame();
		// total length below the headers, trailing bytes ignored
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 20, 58);
		send_frame();
		// single-byte frame
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 40, 1);
		send_frame();
		// payload longer than the limit
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 140, 88);
		send_frame();
		// payload cut short by frame end
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 60, 64);
		send_frame();
		// largest IP and TCP headers
		build_frame(ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 4'd15, 128, 136);
		send_frame();
		// output held off long enough to back up the input
		hold_request = 1'b1;
		steady_send  = 1'b1;
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 70, 84);
		send_frame();
		steady_send  = 1'b0;
		// top limit against a payload length wider than a byte, cut short
		wait_drained();
		write_limit(8'd255);
		build_frame(ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 4'd5, 297, 74);
		send_frame();
	endtask

	// ------------------------------------------------------------------------
	// Random frames: mostly well-formed TCP, the rest broken or noise
	// ------------------------------------------------------------------------
	task automatic send_random_frame();
		int unsigned pick;
		int unsigned ihl;
		int unsigned tcpw;
		int unsigned hdr;
		int unsigned hend;
		int unsigned plen;
		int unsigned tot;
		int unsigned cap;
		int unsigned c;
		logic [15:0] etype;
		logic [7:0]  proto;
		steady_send = ($urandom_range(0, 4) == 0);
		pick = $urandom_range(0, 99);
		ihl  = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
		tcpw = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(5, 15);
		hdr  = (ihl + tcpw) * 4;
		hend = 14 + hdr;
		plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
		tot  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : hdr + plen;
		c = $urandom_range(0, 99);
		if (c < 15)
			cap = hend;
		else if (c < 30)
			cap = hend + $urandom_range(0, plen);
		else if (c < 55)
			cap = hend + plen;
		else
			cap = hend + plen + $urandom_range(1, 8);
		etype = ETHERTYPE_IPV4;
		proto = PROTO_TCP;
		if (pick < 70) begin
			build_frame(etype, 4'(ihl), proto, 4'(tcpw), tot, cap);
		end else if (pick < 78) begin
			etype = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 1) == 1)
				etype[15:8] = ETHERTYPE_IPV4[15:8];
			if (etype == ETHERTYPE_IPV4)
				etype[0] = 1'b1;
			build_frame(etype, 4'(ihl), proto, 4'(tcpw), tot, cap);
		end else if (pick < 84) begin
			proto = 8'($urandom_range(0, 255));
			if (proto == PROTO_TCP)
				proto[7] = 1'b1;
			build_frame(etype, 4'(ihl), proto, 4'(tcpw), tot, cap);
		end else if (pick < 90) begin
			if ($urandom_range(0, 1) == 1)
				ihl = $urandom_range(0, 4);
			else
				tcpw = $urandom_range(0, 4);
			build_frame(etype, 4'(ihl), proto, 4'(tcpw), tot, cap);
		end else if (pick < 95) begin
			build_frame(etype, 4'(ihl), proto, 4'(tcpw), tot, $urandom_range(1, hend - 1));
		end else begin
			frame_buf.delete();
			repeat ($urandom_range(1, 30))
				frame_buf.push_back(8'($urandom_range(0, 255)));
		end
		send_frame();
		steady_send = 1'b0;
	endtask

	task automatic run_random();
		logic [7:0] phase_limits[6];
		int         goal;
		phase_limits = '{8'd32, 8'd3, 8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254))};
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			write_limit(phase_limits[ph]);
			if (ph == 0 || $urandom_range(0, 2) == 0)
				hold_request = 1'b1;
			// share what is left of the item budget among the phases left
			goal = sb.in_beats + (ITEM_GOAL - sb.in_beats) / (6 - ph);
			do
				send_random_frame();
			while (sb.in_beats < goal);
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: random stall with quiet stretches and, on request, a long hold
	// ------------------------------------------------------------------------
	initial begin
		int unsigned stall_left;
		int unsigned run_left;
		int unsigned r;
		rec_stall  = 1'b0;
		stall_left = 0;
		run_left   = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
				run_left     = 0;
			end
			if (stall_left == 0 && run_left == 0) begin
				r = $urandom_range(0, 99);
				if (r < 12)
					run_left = $urandom_range(50, 150);
				else if (r < 40)
					stall_left = pick_gap();
				else
					run_left = $urandom_range(1, 8);
				if (stall_left == 0 && run_left == 0)
					run_left = 1;
			end
			if (stall_left > 0) begin
				rec_stall <= 1'b1;
				stall_left--;
			end else begin
				rec_stall <= 1'b0;
				run_left--;
			end
		end
	end

	// output beat monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rec_valid === 1'b1 && rec_stall === 1'b0)
			sb.check_record(rec_data);
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		byte_data    = '0;
		limit_we     = 1'b0;
		limit_wdata  = '0;
		steady_send  = 1'b0;
		hold_request = 1'b0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		wait_drained();
		sb.close_out();
		if (sb.errors == 0)
			$display("PASS eth_ipv4_tcp_header_extractor");
		else
			$display("FAIL eth_ipv4_tcp_header_extractor");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("FAIL eth_ipv4_tcp_header_extractor");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/ethx_pkg.sv
sv/ethx_parser.sv
sv/ethx_rq.sv
sv/eth_ipv4_tcp_header_extractor.sv
test/eth_ipv4_tcp_header_extractor_tb.sv
